// ===== hdl/wqe_pkg.sv =====
// ----------------------------------------------------------------------------
// wqe_pkg
// shared types and constants for the weighted quantile extractor
// ----------------------------------------------------------------------------
package wqe_pkg;

    localparam int ENTRIES       = 1024;
    localparam int MAX_QUANTILES = 64;
    localparam int AW            = $clog2(ENTRIES);
    localparam int CW            = AW + 1;
    localparam int QIW           = 6;
    localparam int QCW           = 7;
    localparam int CFG_W         = 32;

    localparam logic       FUNC_LOAD    = 1'b0;
    localparam logic       FUNC_QUERY   = 1'b1;
    localparam logic [0:0] REG_TOTAL    = 1'd0;
    localparam logic [0:0] REG_QUANTILE = 1'd1;

    typedef struct packed {
        logic               func;
        logic signed [31:0] value;
        logic        [15:0] weight;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] quantile_value;
        logic [QIW-1:0]     quantile_index;
        logic               found;
        logic               overflow;
        logic               last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_S_RD,
        ST_S_CMP,
        ST_S_WR,
        ST_W_RD,
        ST_W_WAIT,
        ST_W_ACC,
        ST_W_CMP,
        ST_FILL
    } t_state;

endpackage

// ===== hdl/weighted_quantile_extract.sv =====
// ----------------------------------------------------------------------------
// weighted_quantile_extract
// stores weighted summary entries, then on query sorts them and reports
// evenly spaced quantiles of the running weight
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  input     in   i_start & !o_busy         i_item   (func, value, weight)
//  result    out  o_strobe, one cycle       o_result (value, index, flags)
//  config    in   i_cfg_we                  i_cfg_index, i_cfg_data
//
//  a load item is written straight into the store, or sets the overflow flag
//  when the store is full; a query runs the step divide (one quotient bit a
//  cycle), an insertion sort with each element move over the single store
//  port, then a walk over the entries, a fill result per unreached quantile
//  and a finish
//  results leave at most one a cycle; the receiver cannot stall them
//  synchronous active-low reset clears the state machine, count and flags
module weighted_quantile_extract (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  wqe_pkg::t_in_item      i_item,
    output logic                   o_strobe,
    output wqe_pkg::t_out_item     o_result,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [wqe_pkg::CFG_W-1:0] i_cfg_data
);
    import wqe_pkg::*;

    // store: one memory of value and weight, one port, registered read
    logic [47:0]   r_mem [ENTRIES];
    logic [47:0]   r_rd;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [47:0]   mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        r_rd <= r_mem[mem_addr];
    end

    // registers
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [31:0]     r_total;
    logic [QCW-1:0]  r_qcfg;
    logic [QCW-1:0]  r_qn, n_qn;
    // divider: remainder and quotient, shifted one bit a cycle
    logic [32:0]     r_rem, n_rem;
    logic [31:0]     r_quo, n_quo;
    logic [5:0]      r_dcnt, n_dcnt;
    logic [31:0]     r_thr, n_thr;     // (j+1)*step kept by adding step
    // sort cursors
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_p, n_p;
    logic [47:0]     r_key, n_key;
    // walk
    logic [47:0]     r_cum, n_cum;
    logic [47:0]     r_ent, n_ent;
    logic [QIW:0]    r_j, n_j;
    logic            n_strobe, r_strobe;
    t_out_item       n_res, r_res;

    logic [QCW-1:0]  qsat;
    logic [32:0]     rem_sh;
    logic [32:0]     rem_sub;

    always_comb begin
        if (r_qcfg == '0) begin
            qsat = QCW'(1);
        end else if (r_qcfg > QCW'(MAX_QUANTILES)) begin
            qsat = QCW'(MAX_QUANTILES);
        end else begin
            qsat = r_qcfg;
        end
    end

    assign rem_sh  = {r_rem[31:0], r_quo[31]};
    assign rem_sub = rem_sh - {26'd0, r_qn + QCW'(1)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= 32'd1;
            r_qcfg  <= QCW'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_TOTAL) begin
                r_total <= i_cfg_data;
            end else begin
                r_qcfg <= i_cfg_data[QCW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_strobe <= n_strobe;
        end
        r_qn   <= n_qn;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dcnt <= n_dcnt;
        r_thr  <= n_thr;
        r_i    <= n_i;
        r_p    <= n_p;
        r_key  <= n_key;
        r_cum  <= n_cum;
        r_ent  <= n_ent;
        r_j    <= n_j;
        r_res  <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_qn     = r_qn;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_dcnt   = r_dcnt;
        n_thr    = r_thr;
        n_i      = r_i;
        n_p      = r_p;
        n_key    = r_key;
        n_cum    = r_cum;
        n_ent    = r_ent;
        n_j      = r_j;
        n_strobe = 1'b0;
        n_res    = r_res;
        mem_we   = 1'b0;
        mem_addr = r_p[AW-1:0];
        mem_wd   = r_key;
        case (r_state)
            ST_IDLE: begin
                mem_addr = r_count[AW-1:0];
                mem_wd   = {i_item.value, i_item.weight};
                if (i_start) begin
                    if (i_item.func == FUNC_LOAD) begin
                        if (r_count == CW'(ENTRIES)) begin
                            n_ovf = 1'b1;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end else begin
                        n_qn    = qsat;
                        n_rem   = '0;
                        n_quo   = r_total;
                        n_dcnt  = '0;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                // restoring divide total / (qn+1)
                if (!rem_sub[32]) begin
                    n_rem = rem_sub;
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_quo = {r_quo[30:0], 1'b0};
                end
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == 6'd31) begin
                    n_i     = CW'(1);
                    n_state = ST_S_RD;
                end
            end
            ST_S_RD: begin
                // pick element i as key; p walks down
                if (r_i >= r_count) begin
                    n_thr   = r_quo;
                    n_cum   = '0;
                    n_j     = '0;
                    n_i     = '0;
                    n_state = ST_W_RD;
                end else begin
                    mem_addr = r_i[AW-1:0];
                    n_p      = r_i;
                    n_state  = ST_S_CMP;
                end
            end
            ST_S_CMP: begin
                // on entry from the key read (p == i) capture key; read p-1
                if (r_p == r_i) begin
                    n_key = r_rd;
                end
                mem_addr = r_p[AW-1:0] - AW'(1);
                n_state  = ST_S_WR;
            end
            ST_S_WR: begin
                if (r_p != '0 && $signed(r_rd[47:16]) > $signed(r_key[47:16])) begin
                    mem_we   = 1'b1;
                    mem_addr = r_p[AW-1:0];
                    mem_wd   = r_rd;
                    n_p      = r_p - CW'(1);
                    n_state  = ST_S_CMP;
                end else begin
                    mem_we   = 1'b1;
                    mem_addr = r_p[AW-1:0];
                    mem_wd   = r_key;
                    n_i      = r_i + CW'(1);
                    n_state  = ST_S_RD;
                end
            end
            ST_W_RD: begin
                mem_addr = r_i[AW-1:0];
                if (r_i >= r_count || r_j == r_qn) begin
                    n_state = ST_FILL;
                end else begin
                    n_state = ST_W_WAIT;
                end
            end
            ST_W_WAIT: begin
                // hold the address so the read data stays on entry i
                mem_addr = r_i[AW-1:0];
                n_state  = ST_W_ACC;
            end
            ST_W_ACC: begin
                n_ent   = r_rd;
                n_cum   = r_cum + {32'd0, r_rd[15:0]};
                n_state = ST_W_CMP;
            end
            ST_W_CMP: begin
                if (r_cum >= {16'd0, r_thr} || r_thr == '0) begin
                    n_strobe             = 1'b1;
                    n_res.quantile_value = r_ent[47:16];
                    n_res.quantile_index = r_j[QIW-1:0];
                    n_res.found          = 1'b1;
                    n_res.overflow       = r_ovf;
                    n_res.last           = (r_j + 7'd1) == r_qn;
                    n_j                  = r_j + 7'd1;
                    n_thr                = r_thr + r_quo;
                    // threshold past 32 bits cannot be reached by 1024*65535
                    if (r_thr + r_quo < r_thr) begin
                        n_thr = 32'hFFFF_FFFF;
                    end
                end
                n_i     = r_i + CW'(1);
                n_state = ST_W_RD;
            end
            ST_FILL: begin
                if (r_j == r_qn) begin
                    n_count = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_strobe             = 1'b1;
                    n_res.quantile_value = '0;
                    n_res.quantile_index = r_j[QIW-1:0];
                    n_res.found          = 1'b0;
                    n_res.overflow       = r_ovf;
                    n_res.last           = (r_j + 7'd1) == r_qn;
                    n_j                  = r_j + 7'd1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy   = r_state != ST_IDLE;
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // store never grows past its depth
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES)) else $error("entry count past depth");
    // results only during a query
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_W_CMP || r_state == ST_FILL))
        else $error("result outside query");
    // query ends with an empty store
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL && r_j == r_qn) |=> r_count == '0)
        else $error("store not emptied");

endmodule

// ===== tb/wqe_checker.sv =====
// ----------------------------------------------------------------------------
// wqe_checker
// watches the item, config and result channels of weighted_quantile_extract,
// keeps its own copy of the summary store and predicts each quantile result
// ----------------------------------------------------------------------------
module wqe_checker
    import wqe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  t_in_item            i_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_strobe,
    input  t_out_item           i_result,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [31:0] store_value [ENTRIES];
    logic        [15:0] store_weight [ENTRIES];
    int                 store_count;
    logic               overflow_seen;
    logic        [31:0] total_count;
    logic        [6:0]  quantile_count;
    t_out_item          quantile_queue [$];

    assign o_pending = quantile_queue.size();

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // stable ascending sort, then the weighted walk
    task automatic predict_quantiles();
        logic signed [31:0] vals [$];
        logic        [15:0] wts [$];
        logic signed [31:0] v;
        logic        [15:0] w;
        int                 p;
        int                 qn;
        int                 j;
        logic        [31:0] step;
        logic        [63:0] cum;
        t_out_item          r;
        for (int i = 0; i < store_count; i++) begin
            vals.push_back(store_value[i]);
            wts.push_back(store_weight[i]);
        end
        for (int i = 1; i < store_count; i++) begin
            v = vals[i];
            w = wts[i];
            p = i;
            while (p > 0 && vals[p-1] > v) begin
                vals[p] = vals[p-1];
                wts[p]  = wts[p-1];
                p--;
            end
            vals[p] = v;
            wts[p]  = w;
        end
        qn = quantile_count;
        if (qn < 1) qn = 1;
        if (qn > MAX_QUANTILES) qn = MAX_QUANTILES;
        step = total_count / (qn + 1);
        cum  = 0;
        j    = 0;
        for (int i = 0; i < store_count && j < qn; i++) begin
            cum += wts[i];
            if (cum >= 64'(j + 1) * 64'(step)) begin
                r.quantile_value = vals[i];
                r.quantile_index = QIW'(j);
                r.found          = 1'b1;
                r.overflow       = overflow_seen;
                r.last           = (j + 1 == qn);
                quantile_queue.push_back(r);
                j++;
            end
        end
        for (; j < qn; j++) begin
            r.quantile_value = '0;
            r.quantile_index = QIW'(j);
            r.found          = 1'b0;
            r.overflow       = overflow_seen;
            r.last           = (j + 1 == qn);
            quantile_queue.push_back(r);
        end
        store_count = 0;
    endtask

    initial begin
        o_fail_count   = 0;
        o_results_seen = 0;
        store_count    = 0;
        overflow_seen  = 1'b0;
        total_count    = 32'd1;
        quantile_count = 7'd1;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            store_count    = 0;
            overflow_seen  = 1'b0;
            total_count    = 32'd1;
            quantile_count = 7'd1;
            quantile_queue.delete();
        end else begin
            if (i_strobe) begin
                o_results_seen++;
                if (quantile_queue.size() == 0) begin
                    $display("%0t ns: result with nothing expected", $realtime);
                    o_fail_count++;
                end else begin
                    want = quantile_queue.pop_front();
                    if (i_result.quantile_value !== want.quantile_value)
                        report_mismatch("quantile_value", i_result.quantile_value,
                                        want.quantile_value);
                    if (i_result.quantile_index !== want.quantile_index)
                        report_mismatch("quantile_index", i_result.quantile_index,
                                        want.quantile_index);
                    if (i_result.found !== want.found)
                        report_mismatch("found", i_result.found, want.found);
                    if (i_result.overflow !== want.overflow)
                        report_mismatch("overflow", i_result.overflow, want.overflow);
                    if (i_result.last !== want.last)
                        report_mismatch("last", i_result.last, want.last);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TOTAL) total_count = i_cfg_data;
                else quantile_count = i_cfg_data[6:0];
            end
            if (i_start && !i_busy) begin
                if (i_item.func == FUNC_LOAD) begin
                    if (store_count < ENTRIES) begin
                        store_value[store_count]  = i_item.value;
                        store_weight[store_count] = i_item.weight;
                        store_count++;
                    end else begin
                        overflow_seen = 1'b1;
                    end
                end else begin
                    predict_quantiles();
                end
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for weighted_quantile_extract: directed corner items,
// then random load groups closed by queries under changing register settings
// ----------------------------------------------------------------------------
module tb;
    import wqe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    t_in_item           i_item;
    logic               o_strobe;
    t_out_item          o_result;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;

    int                 fail_count;
    int                 pending;
    int                 results_seen;
    int                 idle_pct;       // sender idle chance per cycle, in percent
    int                 loads_sent;
    int                 queries_sent;
    longint unsigned    group_weight;   // weight loaded since the last query

    weighted_quantile_extract uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    wqe_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_strobe       (o_strobe),
        .i_result       (o_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20ms;
        $display("timeout");
        $display("simulation failed");
        $finish;
    end

    // present one item, idling first at random; start stays high on return
    task automatic send_item(input logic func, input logic [31:0] value,
                             input logic [15:0] weight);
        while ($urandom_range(99, 0) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_item.func   <= func;
        i_item.value  <= value;
        i_item.weight <= weight;
        do @(posedge i_clk); while (o_busy);
        if (func == FUNC_LOAD) begin
            loads_sent++;
            group_weight += weight;
        end else begin
            queries_sent++;
            group_weight = 0;
        end
    endtask

    task automatic load(input logic [31:0] value, input logic [15:0] weight);
        send_item(FUNC_LOAD, value, weight);
    endtask

    task automatic query();
        send_item(FUNC_QUERY, $urandom, 16'($urandom));
    endtask

    // wait until every predicted result is out and the block is back at rest
    task automatic wait_quiet();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register writes only ever happen from a quiet block
    task automatic write_reg(input logic idx, input logic [31:0] data);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(9, 0))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(20, 1));
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5, 0))
            0:       return 32'($urandom_range(3, 0)) << 16;   // frequent ties
            1:       return $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int n;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_item       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_TOTAL;
        i_cfg_data   = '0;
        idle_pct     = 0;
        loads_sent   = 0;
        queries_sent = 0;
        group_weight = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store under reset settings: one not-found result
        query();
        // extremes of value and weight, ties and a zero weight
        write_reg(REG_TOTAL, 32'd100);
        write_reg(REG_QUANTILE, 32'd3);
        load(32'h7FFF_FFFF, 16'hFFFF);
        load(32'h8000_0000, 16'd1);
        load(32'h0001_0000, 16'd0);
        load(32'h0001_0000, 16'd30);
        load(32'hFFFF_0000, 16'd30);
        query();
        // small total count: step is zero, every entry answers a quantile
        write_reg(REG_TOTAL, 32'd2);
        write_reg(REG_QUANTILE, 32'd4);
        load(32'h0000_0005, 16'd1);
        load(32'hFFFF_FFFB, 16'd2);
        query();
        // quantile count zero saturates to one
        write_reg(REG_QUANTILE, 32'd0);
        load(32'h1234_5678, 16'd7);
        query();
        // out of range count saturates to the maximum, huge total unreached
        write_reg(REG_TOTAL, 32'hFFFF_FFFF);
        write_reg(REG_QUANTILE, 32'h7F);
        load(32'hA5A5_5A5A, 16'hFFFF);
        load(32'h5A5A_A5A5, 16'h8000);
        query();
        write_reg(REG_TOTAL, 32'd0);
        write_reg(REG_QUANTILE, 32'd64);
        load(32'h0000_0001, 16'd1);
        query();

        // random groups of loads, each closed by a query
        n = 0;
        while (n < 470) begin
            case ((n / 60) % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 82;
                2:       idle_pct = 14;
                default: idle_pct = 0;
            endcase
            if ($urandom_range(2, 0) == 0) begin
                // change settings from a quiet block
                write_reg(REG_QUANTILE, $urandom_range(4, 0) == 0 ?
                          32'($urandom_range(127, 0)) : 32'($urandom_range(64, 1)));
                write_reg(REG_TOTAL, 32'($urandom_range(600, 1)));
            end
            repeat ($urandom_range(25, 0)) begin
                load(pick_value(), pick_weight());
                n++;
            end
            if ($urandom_range(3, 0) == 0)
                load($urandom, 16'($urandom));
            if ($urandom_range(4, 0) == 0) begin
                // retune total to the loaded weight so thresholds get reached, or to a random or tiny value
                write_reg(REG_TOTAL, $urandom_range(1, 0) ? 32'(group_weight) :
                          (($urandom_range(1, 0)) ? $urandom : 32'($urandom_range(3, 0))));
            end
            query();
            n++;
        end

        wait_quiet();
        repeat (20) @(posedge i_clk);
        $display("covered %0d loads and %0d queries, %0d quantile results checked",
                 loads_sent, queries_sent, results_seen);
        $display("including saturated counts, zero steps, ties and idle phases");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
